>>> hdl/pwl_lut_pkg.sv
// Shared types and codes for the piecewise-linear profile lookup unit.
// Holds the transfer payload structs and the result status codes; no dependencies.
package pwl_lut_pkg;

    localparam logic [1:0] ST_INTERP     = 2'd0;
    localparam logic [1:0] ST_HOLD_FIRST = 2'd1;
    localparam logic [1:0] ST_HOLD_LAST  = 2'd2;
    localparam logic [1:0] ST_WRITE      = 2'd3;

    localparam int CFG_W = 7;

    typedef struct packed {
        logic               mode;
        logic        [5:0]  entry_index;
        logic signed [31:0] time_value;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
    } pwl_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [1:0]  status;
    } pwl_res_t;

endpackage

>>> hdl/pwl_lut_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the breakpoint time and vector tables.
module pwl_lut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

>>> hdl/piecewise_linear_profile_lookup_unit.sv
// Top level of the piecewise-linear profile lookup unit: sequencer, bisection,
// divider and shared multiplier. Depends on pwl_lut_pkg and pwl_lut_ram.
//
// Channel   Direction  Handshake           Payload
// item      in         start, busy         pwl_in_t
// result    out        done (strobe)       pwl_res_t
// config    in         cfg_we              cfg_data (entries in use)
//
// A write item is taken in its transfer cycle, busy stays low and its result strobes next cycle.
// A query keeps busy high while it holds at the first entry, holds at the last, or bisects and
// interpolates through the 16-step restoring divider and the shared multiplier; a time on the
// upper breakpoint skips the divider. The result strobes as busy falls. Reset clears the
// sequencer and sets entries in use to two; the tables are undefined until written. Results
// cannot be stalled.
module piecewise_linear_profile_lookup_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pwl_lut_pkg::pwl_in_t        item,
    output logic                        done,
    output pwl_lut_pkg::pwl_res_t       result,
    input  logic                        cfg_we,
    input  logic [pwl_lut_pkg::CFG_W-1:0] cfg_data
);

    import pwl_lut_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] MIN_C   = CW'(2);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHK_FIRST = 4'd1;
    localparam logic [3:0] S_CHK_LAST  = 4'd2;
    localparam logic [3:0] S_BIS       = 4'd3;
    localparam logic [3:0] S_RD_LO     = 4'd4;
    localparam logic [3:0] S_RD_HI     = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_ADD       = 4'd8;
    localparam logic [3:0] S_HOLD      = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CFG_W-1:0]   n_reg;
    logic [AW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic [1:0]         stat_reg, stat_next;
    logic               done_reg, done_next;
    pwl_res_t           result_reg, result_next;

    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] tlo_reg, tlo_next;
    logic [31:0]        len_reg, len_next;
    logic [32:0]        rem_reg, rem_next;
    logic [15:0]        w_reg, w_next;
    logic [95:0]        va_reg, va_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic signed [49:0] prod_reg, prod_next;

    logic [CW-1:0]      n_ext, n_clamp, hi_lim_w;
    logic [AW-1:0]      hi_lim;
    logic               we_w;
    logic [AW-1:0]      t_raddr, v_raddr;
    logic [31:0]        t_rdata;
    logic [95:0]        v_rdata;
    logic signed [31:0] t_rd;
    logic [AW-1:0]      bis_lo, bis_hi;
    logic [AW:0]        mid_sum, bis_sum;
    logic signed [32:0] len_w, off_w;
    logic [32:0]        rem2;
    logic               rem_ge;
    logic signed [32:0] diff_sel;
    logic signed [31:0] a_sel;
    logic signed [33:0] sum_w;

    assign n_ext    = CW'(n_reg);
    assign n_clamp  = (n_ext < MIN_C) ? MIN_C : ((n_ext > DEPTH_C) ? DEPTH_C : n_ext);
    assign hi_lim_w = n_clamp - CW'(1);
    assign hi_lim   = hi_lim_w[AW-1:0];

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign we_w = start && !busy && !item.mode
                  && (32'(item.entry_index) < 32'(TABLE_DEPTH));

    pwl_lut_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (we_w),
        .waddr (AW'(item.entry_index)),
        .wdata (item.time_value),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    pwl_lut_ram #(
        .WIDTH (96),
        .DEPTH (TABLE_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (we_w),
        .waddr (AW'(item.entry_index)),
        .wdata ({item.entry_x, item.entry_y, item.entry_z}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    assign t_rd = $signed(t_rdata);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign bis_lo  = (t_rd < t_reg) ? mid_sum[AW:1] : lo_reg;
    assign bis_hi  = (t_rd < t_reg) ? hi_reg : mid_sum[AW:1];
    assign bis_sum = {1'b0, bis_lo} + {1'b0, bis_hi};

    assign len_w = $signed({t_rd[31], t_rd}) - $signed({tlo_reg[31], tlo_reg});
    assign off_w = $signed({t_reg[31], t_reg}) - $signed({tlo_reg[31], tlo_reg});

    assign rem2   = {rem_reg[31:0], 1'b0};
    assign rem_ge = (rem2 >= {1'b0, len_reg});

    always_comb
    begin
        unique case (comp_reg)
            2'd0:
            begin
                diff_sel = dx_reg;
                a_sel    = $signed(va_reg[95:64]);
            end
            2'd1:
            begin
                diff_sel = dy_reg;
                a_sel    = $signed(va_reg[63:32]);
            end
            default:
            begin
                diff_sel = dz_reg;
                a_sel    = $signed(va_reg[31:0]);
            end
        endcase
    end

    assign sum_w = $signed({{2{a_sel[31]}}, a_sel}) + $signed(prod_reg[49:16]);

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        comp_next   = comp_reg;
        stat_next   = stat_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        t_next      = t_reg;
        tlo_next    = tlo_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        w_next      = w_reg;
        va_next     = va_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        prod_next   = prod_reg;
        t_raddr     = '0;
        v_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!item.mode)
                    begin
                        result_next        = '0;
                        result_next.status = ST_WRITE;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        t_next     = item.time_value;
                        state_next = S_CHK_FIRST;
                    end
                end
            end
            S_CHK_FIRST:
            begin
                if (t_reg <= t_rd)
                begin
                    stat_next  = ST_HOLD_FIRST;
                    state_next = S_HOLD;
                end
                else
                begin
                    t_raddr    = hi_lim;
                    state_next = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                lo_next = '0;
                hi_next = hi_lim;
                if (t_reg >= t_rd)
                begin
                    v_raddr    = hi_lim;
                    stat_next  = ST_HOLD_LAST;
                    state_next = S_HOLD;
                end
                else if (hi_lim == AW'(1))
                begin
                    state_next = S_RD_LO;
                end
                else
                begin
                    t_raddr    = hi_lim >> 1;
                    state_next = S_BIS;
                end
            end
            S_BIS:
            begin
                lo_next = bis_lo;
                hi_next = bis_hi;
                if (bis_hi == bis_lo + AW'(1))
                begin
                    t_raddr    = bis_lo;
                    v_raddr    = bis_lo;
                    state_next = S_RD_LO;
                end
                else
                begin
                    t_raddr = bis_sum[AW:1];
                end
            end
            S_RD_LO:
            begin
                tlo_next   = t_rd;
                va_next    = v_rdata;
                t_raddr    = lo_reg + AW'(1);
                v_raddr    = lo_reg + AW'(1);
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                len_next  = len_w[31:0];
                rem_next  = {1'b0, off_w[31:0]};
                dx_next   = $signed({v_rdata[95], v_rdata[95:64]})
                            - $signed({va_reg[95], va_reg[95:64]});
                dy_next   = $signed({v_rdata[63], v_rdata[63:32]})
                            - $signed({va_reg[63], va_reg[63:32]});
                dz_next   = $signed({v_rdata[31], v_rdata[31:0]})
                            - $signed({va_reg[31], va_reg[31:0]});
                cnt_next  = '0;
                comp_next = '0;
                if (off_w[31:0] == len_w[31:0])
                begin
                    w_next     = 16'hFFFF;
                    state_next = S_MUL;
                end
                else
                begin
                    w_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? rem2 - {1'b0, len_reg} : rem2;
                w_next   = {w_reg[14:0], rem_ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = diff_sel * $signed({1'b0, w_reg});
                state_next = S_ADD;
            end
            S_ADD:
            begin
                unique case (comp_reg)
                    2'd0:    result_next.out_x = sum_w[31:0];
                    2'd1:    result_next.out_y = sum_w[31:0];
                    default: result_next.out_z = sum_w[31:0];
                endcase
                if (comp_reg == 2'd2)
                begin
                    result_next.status = ST_INTERP;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_HOLD:
            begin
                result_next.out_x  = $signed(v_rdata[95:64]);
                result_next.out_y  = $signed(v_rdata[63:32]);
                result_next.out_z  = $signed(v_rdata[31:0]);
                result_next.status = stat_reg;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= CFG_W'(2);
            lo_reg    <= '0;
            hi_reg    <= '0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            stat_reg  <= ST_INTERP;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            stat_reg  <= stat_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                n_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        t_reg      <= t_next;
        tlo_reg    <= tlo_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        w_reg      <= w_next;
        va_reg     <= va_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        prod_reg   <= prod_next;
    end

    // A result strobe always coincides with the sequencer being free again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.mode) |=> (done && result.status == ST_WRITE))
        else $error("write transfer not answered in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode) |=> busy)
        else $error("query transfer did not start the sequencer");

    // The bisection bounds stay at least two apart while searching.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIS) |-> (hi_reg > lo_reg + AW'(1)))
        else $error("bisection bounds collapsed");

endmodule
